// ===== rtl/core/extent_runlist_decoder_macros.svh =====
// Assertion helpers; the including scope supplies clk and rst_n.
`ifndef EXTENT_RUNLIST_DECODER_MACROS_SVH
`define EXTENT_RUNLIST_DECODER_MACROS_SVH

// Same-cycle implication.
`define ERD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ERD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/erd_pkg.sv =====
`timescale 1ns / 1ps

package erd_pkg;

    localparam int MAX_RUNS_DEF = 64;
    localparam int IDX_OUT_W    = 7;

    typedef enum logic [2:0] {
        KIND_RUN  = 3'd0,
        KIND_END  = 3'd1,
        KIND_HIT  = 3'd2,
        KIND_MISS = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] nxt;
        logic [63:0] lcn;
        logic [31:0] alloc;
    } entry_t;

    // Lookup token travelling down the cell row
    typedef struct packed {
        logic                 active;
        logic                 found;
        logic [62:0]          q;
        logic [IDX_OUT_W-1:0] idx;
        entry_t               ent;
    } scan_t;

    // Sign-extend a little-endian field of nbytes bytes; zero bytes gives 0
    function automatic logic [63:0] sext_field(input logic [63:0] acc,
                                               input logic [3:0]  nbytes);
        logic [63:0] r;
        r = 64'd0;
        unique case (nbytes)
            4'd1:    r = {{56{acc[7]}},  acc[7:0]};
            4'd2:    r = {{48{acc[15]}}, acc[15:0]};
            4'd3:    r = {{40{acc[23]}}, acc[23:0]};
            4'd4:    r = {{32{acc[31]}}, acc[31:0]};
            4'd5:    r = {{24{acc[39]}}, acc[39:0]};
            4'd6:    r = {{16{acc[47]}}, acc[47:0]};
            4'd7:    r = {{8{acc[55]}},  acc[55:0]};
            4'd8:    r = acc;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/erd_cell.sv =====
`timescale 1ns / 1ps

module erd_cell
    import erd_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_ent,
    input  logic   live,
    input  scan_t  tok_in,
    output scan_t  tok_out
);

    entry_t ent_reg;
    scan_t  tok_reg;
    scan_t  tok_next;
    logic   hit;

    // start <= q < next, signed 64-bit
    always_comb
    begin
        hit = tok_in.active && !tok_in.found && live
              && ($signed(ent_reg.start) <= $signed({1'b0, tok_in.q}))
              && ($signed(ent_reg.nxt) > $signed({1'b0, tok_in.q}));
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = IDX_OUT_W'(IDX);
            tok_next.ent   = ent_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg <= wr_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/extent_runlist_decoder.sv =====
// Run-list byte: result (if any) registered at the transfer edge, valid the next cycle.
// Lookup: query walks the cell row one cell per cycle, is captured in the capture stage, then
//   the LCN add goes into the output register; next item taken once the result is registered.
// Reset: parser, counters and output valid cleared; table contents stay undefined,
//   no clearing pass (only entries below the run count are ever read).
`timescale 1ns / 1ps
`include "extent_runlist_decoder_macros.svh"

module extent_runlist_decoder
    import erd_pkg::*;
#(
    parameter int MAX_RUNS = MAX_RUNS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [62:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         list_byte,
    input  logic               list_start,
    input  logic [62:0]        query_vcn,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [62:0]        run_start_vcn,
    output logic [62:0]        run_next_vcn,
    output logic signed [63:0] lcn,
    output logic signed [31:0] run_length,
    output logic signed [31:0] alloc_count,
    output logic [6:0]         run_index
);

    localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CW = $clog2(MAX_RUNS + 1);

    // Parser phase and control sequencer, both one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_OFFSET = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIX  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [62:0] start_vcn_reg;
    logic [3:0]  lsz_reg, lsz_next;
    logic [3:0]  osz_reg, osz_next;
    logic [3:0]  seen_reg, seen_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] vcn_reg, vcn_next;
    logic [63:0] lcn_reg, lcn_next;
    logic [63:0] begin_reg, begin_next;
    logic [CW-1:0] count_reg, count_next;

    // Lookup capture stage
    scan_t       hold_reg;
    logic [63:0] diff_reg;
    logic [31:0] len_reg;

    // Output register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [62:0] out_start_reg, out_next_reg;
    logic [63:0] out_lcn_reg;
    logic [31:0] out_len_reg, out_alloc_reg;
    logic [6:0]  out_idx_reg;

    logic        in_accept;
    logic        res_valid;
    kind_t       res_kind;
    logic [62:0] res_start, res_next;
    logic [63:0] res_lcn;
    logic [31:0] res_len, res_alloc;
    logic [6:0]  res_idx;
    logic        wr_en;
    entry_t      wr_ent;
    logic [IW-1:0] wr_idx;

    scan_t       tok [0:MAX_RUNS];
    logic [MAX_RUNS-1:0] live;

    assign in_stall  = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Run-list parser: one byte per transfer, result straight to output reg
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [63:0]   vcn_b, lcn_b, vcn_f, lcn_f, begin_f, acc_new, len64;
        logic [CW-1:0] cnt_b;
        logic [3:0]    nib_l, nib_o, osz_f;
        logic          fin;

        phase_next = phase_reg;
        lsz_next   = lsz_reg;
        osz_next   = osz_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        vcn_next   = vcn_reg;
        lcn_next   = lcn_reg;
        begin_next = begin_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_RUN;
        res_start  = '0;
        res_next   = '0;
        res_lcn    = '0;
        res_len    = '0;
        res_alloc  = '0;
        res_idx    = '0;
        wr_en      = 1'b0;
        wr_ent     = '0;

        // list start reloads the running values before the header is read
        vcn_b = list_start ? {1'b0, start_vcn_reg} : vcn_reg;
        lcn_b = list_start ? 64'd0 : lcn_reg;
        cnt_b = (list_start && (start_vcn_reg == 63'd0)) ? '0 : count_reg;
        wr_idx = cnt_b[IW-1:0];

        nib_l   = list_byte[3:0];
        nib_o   = list_byte[7:4];
        osz_f   = osz_reg;
        fin     = 1'b0;
        vcn_f   = vcn_b;
        lcn_f   = lcn_b;
        begin_f = begin_reg;
        acc_new = seen_reg[3] ? acc_reg
                  : (acc_reg | ({56'd0, list_byte} << {seen_reg[2:0], 3'b000}));
        len64   = '0;

        if (in_accept && !func)
        begin
            count_next = cnt_b;
            vcn_next   = vcn_b;
            lcn_next   = lcn_b;
            if (list_start || (phase_reg == PH_HEADER))
            begin
                phase_next = PH_HEADER;
                if (list_byte == 8'd0)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_END;
                    res_idx   = 7'(cnt_b);
                end
                else if ((nib_l > 4'd8) || (nib_o > 4'd8))
                begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_ERR;
                    count_next = '0;
                end
                else
                begin
                    lsz_next   = nib_l;
                    osz_next   = nib_o;
                    osz_f      = nib_o;
                    begin_next = vcn_b;
                    begin_f    = vcn_b;
                    seen_next  = '0;
                    acc_next   = '0;
                    if ((nib_l == 4'd0) && (nib_o == 4'd0))
                    begin
                        fin = 1'b1;
                    end
                    else if (nib_l == 4'd0)
                    begin
                        phase_next = PH_OFFSET;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
            end
            else if (phase_reg == PH_LENGTH)
            begin
                seen_next = 4'(seen_reg + 4'd1);
                acc_next  = acc_new;
                if (seen_next >= lsz_reg)
                begin
                    vcn_f      = vcn_reg + sext_field(acc_new, lsz_reg);
                    vcn_next   = vcn_f;
                    seen_next  = '0;
                    acc_next   = '0;
                    phase_next = PH_OFFSET;
                    if (osz_reg == 4'd0)
                    begin
                        fin = 1'b1;
                    end
                end
            end
            else
            begin
                seen_next = 4'(seen_reg + 4'd1);
                acc_next  = acc_new;
                if (seen_next >= osz_reg)
                begin
                    lcn_f    = lcn_reg + sext_field(acc_new, osz_reg);
                    lcn_next = lcn_f;
                    fin      = 1'b1;
                end
            end

            if (fin)
            begin
                phase_next = PH_HEADER;
                len64      = vcn_f - begin_f;
                res_valid  = 1'b1;
                if (cnt_b >= CW'(MAX_RUNS))
                begin
                    res_kind   = KIND_ERR;
                    count_next = '0;
                end
                else
                begin
                    res_kind  = KIND_RUN;
                    res_start = begin_f[62:0];
                    res_next  = vcn_f[62:0];
                    res_lcn   = lcn_f;
                    res_len   = len64[31:0];
                    // sparse: no offset bytes or LCN of all ones
                    res_alloc = ((osz_f == 4'd0) || (lcn_f == '1)) ? 32'd0 : len64[31:0];
                    res_idx   = 7'(cnt_b);
                    wr_en        = 1'b1;
                    wr_ent.start = begin_f;
                    wr_ent.nxt   = vcn_f;
                    wr_ent.lcn   = lcn_f;
                    wr_ent.alloc = res_alloc;
                    count_next   = CW'(cnt_b + CW'(1));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell row: one table entry per cell, lookup token moves one per cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = in_accept && func;
        tok[0].q      = query_vcn;
    end

    for (genvar g = 0; g < MAX_RUNS; g++)
    begin : g_cell
        assign live[g] = CW'(g) < count_reg;

        erd_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en && (wr_idx == IW'(g))),
            .wr_ent  (wr_ent),
            .live    (live[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && func)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok[MAX_RUNS].active)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            start_vcn_reg <= '0;
            lsz_reg       <= '0;
            osz_reg       <= '0;
            seen_reg      <= '0;
            acc_reg       <= '0;
            vcn_reg       <= '0;
            lcn_reg       <= '0;
            begin_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lsz_reg   <= lsz_next;
            osz_reg   <= osz_next;
            seen_reg  <= seen_next;
            acc_reg   <= acc_next;
            vcn_reg   <= vcn_next;
            lcn_reg   <= lcn_next;
            begin_reg <= begin_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                start_vcn_reg <= cfg_wr_data;
            end
            if (res_valid || (state_reg == S_FIX))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && tok[MAX_RUNS].active)
        begin
            hold_reg <= tok[MAX_RUNS];
            diff_reg <= {1'b0, tok[MAX_RUNS].q} - tok[MAX_RUNS].ent.start;
            len_reg  <= 32'(tok[MAX_RUNS].ent.nxt - tok[MAX_RUNS].ent.start);
        end
        if (res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_start_reg <= res_start;
            out_next_reg  <= res_next;
            out_lcn_reg   <= res_lcn;
            out_len_reg   <= res_len;
            out_alloc_reg <= res_alloc;
            out_idx_reg   <= res_idx;
        end
        else if (state_reg == S_FIX)
        begin
            if (hold_reg.found)
            begin
                out_kind_reg  <= KIND_HIT;
                out_start_reg <= hold_reg.ent.start[62:0];
                out_next_reg  <= hold_reg.ent.nxt[62:0];
                out_lcn_reg   <= hold_reg.ent.lcn + diff_reg;
                out_len_reg   <= len_reg;
                out_alloc_reg <= hold_reg.ent.alloc;
                out_idx_reg   <= hold_reg.idx;
            end
            else
            begin
                out_kind_reg  <= KIND_MISS;
                out_start_reg <= '0;
                out_next_reg  <= '0;
                out_lcn_reg   <= '1;
                out_len_reg   <= '0;
                out_alloc_reg <= '0;
                out_idx_reg   <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign run_start_vcn = out_start_reg;
    assign run_next_vcn  = out_next_reg;
    assign lcn           = out_lcn_reg;
    assign run_length    = out_len_reg;
    assign alloc_count   = out_alloc_reg;
    assign run_index     = out_idx_reg;

    `ERD_ASSERT_IMP(a_busy_stall, state_reg != S_IDLE, in_stall, "transfer taken while busy")
    `ERD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_RUNS), "run count overflow")
    `ERD_ASSERT_NXT(a_lookup_scan, in_valid && !in_stall && func, state_reg == S_SCAN,
                    "lookup did not start scan")
    `ERD_ASSERT_NXT(a_fix_out, state_reg == S_FIX, out_valid_reg, "lookup result lost")

endmodule

// ===== test/extent_runlist_decoder_tb.sv =====
`timescale 1ns / 1ps

module extent_runlist_decoder_tb;
    import erd_pkg::*;

    localparam int RUNS = MAX_RUNS_DEF;
    // a lookup walks the whole cell row, so the drain covers a walk of the whole row
    localparam int DRAIN_CYCLES = RUNS + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;
    localparam logic [62:0] VCN_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {PH_HDR, PH_LEN, PH_OFF} parse_ph_t;

    typedef struct packed {
        kind_t              kind;
        logic [62:0]        start_vcn;
        logic [62:0]        next_vcn;
        logic [63:0]        lcn;
        logic [31:0]        length;
        logic [31:0]        alloc;
        logic [6:0]         index;
    } extent_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [62:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [7:0] list_byte;
    logic list_start;
    logic [62:0] query_vcn;
    logic out_valid;
    logic out_stall;
    logic [2:0] kind;
    logic [62:0] run_start_vcn;
    logic [62:0] run_next_vcn;
    logic signed [63:0] lcn;
    logic signed [31:0] run_length;
    logic signed [31:0] alloc_count;
    logic [6:0] run_index;

    extent_runlist_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .list_byte     (list_byte),
        .list_start    (list_start),
        .query_vcn     (query_vcn),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .run_start_vcn (run_start_vcn),
        .run_next_vcn  (run_next_vcn),
        .lcn           (lcn),
        .run_length    (run_length),
        .alloc_count   (alloc_count),
        .run_index     (run_index)
    );

    // Shadow of the decoder state
    logic [62:0]    sh_start_vcn;
    parse_ph_t      sh_phase;
    int unsigned    sh_len_size;
    int unsigned    sh_off_size;
    int unsigned    sh_bytes_seen;
    logic [63:0]    sh_acc;
    logic [63:0]    sh_vcn;
    logic [63:0]    sh_lcn;
    int unsigned    sh_runs;
    logic [63:0]    sh_begin_vcn;
    logic [63:0]    tab_start [RUNS];
    logic [63:0]    tab_next [RUNS];
    logic [63:0]    tab_lcn [RUNS];
    logic [31:0]    tab_alloc [RUNS];

    extent_result_t pending_results[$];
    int errors = 0;
    int items_sent = 0;
    bit quiet = 0;      // no idling on either side while set
    int idle_cycles = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Sign-extend a little-endian field from its top byte
    function automatic logic [63:0] widen_field(input logic [63:0] acc, input int unsigned n);
        int unsigned sh;
        if (n == 0)
            return 64'd0;
        if (n >= 8)
            return acc;
        sh = 64 - 8 * n;
        return $unsigned($signed(acc << sh) >>> sh);
    endfunction

    function automatic extent_result_t make_result(kind_t k, logic [63:0] s, logic [63:0] n,
                                                   logic [63:0] l, logic [63:0] len,
                                                   logic [31:0] a, int unsigned idx);
        extent_result_t r;
        r.kind = k;
        r.start_vcn = s[62:0];
        r.next_vcn = n[62:0];
        r.lcn = l;
        r.length = len[31:0];
        r.alloc = a;
        r.index = idx[6:0];
        return r;
    endfunction

    task automatic close_run();
        logic [63:0] len;
        logic [31:0] alloc;
        len = sh_vcn - sh_begin_vcn;
        sh_phase = PH_HDR;
        alloc = (sh_off_size == 0 || sh_lcn == '1) ? 32'd0 : len[31:0];
        if (sh_runs >= RUNS)
        begin
            // table full: error and start over
            sh_runs = 0;
            pending_results.push_back(make_result(KIND_ERR, 0, 0, 0, 0, 0, 0));
        end
        else
        begin
            tab_start[sh_runs] = sh_begin_vcn;
            tab_next[sh_runs] = sh_vcn;
            tab_lcn[sh_runs] = sh_lcn;
            tab_alloc[sh_runs] = alloc;
            pending_results.push_back(make_result(KIND_RUN, sh_begin_vcn, sh_vcn, sh_lcn,
                                                  len, alloc, sh_runs));
            sh_runs++;
        end
    endtask

    // Skip empty fields; a zero-size offset closes the run at once
    task automatic skip_empty_fields();
        if (sh_phase == PH_LEN && sh_len_size == 0)
        begin
            sh_phase = PH_OFF;
            sh_bytes_seen = 0;
            sh_acc = 0;
        end
        if (sh_phase == PH_OFF && sh_off_size == 0)
            close_run();
    endtask

    // Works out the result (if any) of one accepted transfer
    task automatic decode_transfer(input logic f, input logic [7:0] b, input logic ls,
                                   input logic [62:0] q);
        logic [63:0] q64;
        bit hit;
        q64 = {1'b0, q};
        if (f)
        begin
            hit = 0;
            for (int i = 0; i < sh_runs && !hit; i++)
            begin
                if ($signed(tab_start[i]) <= $signed(q64) && $signed(q64) < $signed(tab_next[i]))
                begin
                    hit = 1;
                    pending_results.push_back(make_result(KIND_HIT, tab_start[i], tab_next[i],
                        tab_lcn[i] + (q64 - tab_start[i]), tab_next[i] - tab_start[i],
                        tab_alloc[i], i));
                end
            end
            if (!hit)
                pending_results.push_back(make_result(KIND_MISS, 0, 0, '1, 0, 0, 0));
            return;
        end
        if (ls)
        begin
            if (sh_start_vcn == 0)
                sh_runs = 0;
            sh_vcn = {1'b0, sh_start_vcn};
            sh_lcn = 0;
            sh_phase = PH_HDR;
        end
        if (sh_phase == PH_HDR)
        begin
            if (b == 8'h00)
                pending_results.push_back(make_result(KIND_END, 0, 0, 0, 0, 0, sh_runs));
            else if (b[3:0] > 8 || b[7:4] > 8)
            begin
                sh_runs = 0;
                pending_results.push_back(make_result(KIND_ERR, 0, 0, 0, 0, 0, 0));
            end
            else
            begin
                sh_len_size = b[3:0];
                sh_off_size = b[7:4];
                sh_begin_vcn = sh_vcn;
                sh_phase = PH_LEN;
                sh_bytes_seen = 0;
                sh_acc = 0;
                skip_empty_fields();
            end
            return;
        end
        if (sh_bytes_seen < 8)
            sh_acc |= 64'(b) << (8 * sh_bytes_seen);
        sh_bytes_seen++;
        if (sh_phase == PH_LEN)
        begin
            if (sh_bytes_seen >= sh_len_size)
            begin
                sh_vcn += widen_field(sh_acc, sh_len_size);
                sh_phase = PH_OFF;
                sh_bytes_seen = 0;
                sh_acc = 0;
                skip_empty_fields();
            end
        end
        else if (sh_bytes_seen >= sh_off_size)
        begin
            sh_lcn += widen_field(sh_acc, sh_off_size);
            close_run();
        end
    endtask

    // One transfer into the block. Valid is left high unless the task idles;
    // whatever follows must either send again or drop valid in the same step.
    task automatic send_item(input logic f, input logic [7:0] b, input logic ls,
                             input logic [62:0] q);
        in_valid <= 1'b1;
        func <= f;
        list_byte <= b;
        list_start <= ls;
        query_vcn <= q;
        do
            @(posedge clk);
        while (in_stall);
        decode_transfer(f, b, ls, q);
        items_sent++;
        if (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic ls = 1'b0);
        send_item(1'b0, b, ls, 63'({$urandom, $urandom}));
    endtask

    task automatic send_lookup(input logic [62:0] q);
        send_item(1'b1, 8'($urandom), 1'($urandom), q);
    endtask

    // Let every expected result arrive, then the longest in-flight work
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_vcn(input logic [62:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sh_start_vcn = v;
    endtask

    // Query mostly inside stored runs, sometimes anywhere
    function automatic logic [62:0] pick_query();
        logic [63:0] span;
        int unsigned i;
        if (sh_runs == 0 || $urandom_range(0, 3) == 0)
            return 63'({$urandom, $urandom});
        i = $urandom_range(0, sh_runs - 1);
        span = tab_next[i] - tab_start[i];
        if ($signed(span) <= 0)
            return tab_start[i][62:0];
        if (span > 1000)
            span = 1000;
        return 63'(tab_start[i] + $urandom_range(0, int'(span) - 1));
    endfunction

    // One well-formed run list with random content and a little noise
    task automatic send_random_list(input int n_runs, input bit terminate);
        int unsigned ls_sz, of_sz;
        for (int r = 0; r < n_runs; r++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_byte(8'($urandom), 1'($urandom));   // stray byte
            if ($urandom_range(0, 9) == 0)
                send_lookup(pick_query());
            // small fields mostly, the widest now and then
            ls_sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 2);
            of_sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
            if (ls_sz == 0 && of_sz == 0)
                ls_sz = 1;
            send_byte({4'(of_sz), 4'(ls_sz)}, r == 0);
            for (int k = 0; k < ls_sz + of_sz; k++)
                send_byte(8'($urandom));
        end
        if (terminate)
            send_byte(8'h00);
    endtask

    // Results are checked when the transfer happens
    task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        extent_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, kind %0d", $time, kind);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("kind", 64'(e.kind), 64'(kind));
                check_field("run_start_vcn", 64'(e.start_vcn), 64'(run_start_vcn));
                check_field("run_next_vcn", 64'(e.next_vcn), 64'(run_next_vcn));
                check_field("lcn", e.lcn, lcn);
                check_field("run_length", 64'(e.length), 64'($unsigned(run_length)));
                check_field("alloc_count", 64'(e.alloc), 64'($unsigned(alloc_count)));
                check_field("run_index", 64'(e.index), 64'(run_index));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 15);
    end

    // Watchdog: cycles without any transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_basic_list();
        write_start_vcn(63'd0);
        send_byte(8'h11, 1'b1); send_byte(8'h05); send_byte(8'h10);   // plain run
        send_byte(8'h21); send_byte(8'h80); send_byte(8'hFF);         // negative length
        send_byte(8'hF0);
        send_byte(8'h01); send_byte(8'h03);                            // no offset: sparse
        send_byte(8'h10); send_byte(8'hAB);                            // no length field
        send_byte(8'h11); send_byte(8'h02); send_byte(8'hFF);         // LCN offset of -1
        send_byte(8'h88, 1'b1);                                        // widest fields
        repeat (8) send_byte(8'hFF);
        repeat (8) send_byte(8'h7F);
        send_byte(8'h00);
    endtask

    task automatic test_bad_header();
        send_byte(8'h19, 1'b1);
        send_byte(8'h91);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_restart_mid_run();
        send_byte(8'h11, 1'b1); send_byte(8'h04); send_byte(8'h20);
        send_byte(8'h44); send_byte(8'h01); send_byte(8'h02);         // run abandoned
        send_byte(8'h11, 1'b1); send_byte(8'h03); send_byte(8'h07);
        send_byte(8'h00);
    endtask

    task automatic test_lookups();
        send_byte(8'h11, 1'b1); send_byte(8'h08); send_byte(8'h40);
        send_byte(8'h01); send_byte(8'h04);
        send_lookup(63'd0);
        send_lookup(63'd7);
        send_lookup(63'd9);
        send_lookup(63'd12);
        send_lookup(VCN_MAX);
        send_byte(8'h21); send_byte(8'h05);                             // lookup mid-run
        send_lookup(63'd3);
        send_byte(8'h00); send_byte(8'h01);
    endtask

    task automatic test_full_table();
        send_byte(8'h01, 1'b1);
        send_byte(8'h01);
        for (int i = 0; i < RUNS + 1; i++)
        begin
            send_byte(8'h01);
            send_byte(8'h01);
        end
        send_byte(8'h00);
        send_lookup(63'd0);
    endtask

    task automatic test_start_vcn_settings();
        write_start_vcn(VCN_MAX);
        send_random_list(3, 1);
        send_lookup(VCN_MAX);
        write_start_vcn(63'h2AAA_AAAA_5555_5555);
        send_random_list(3, 1);
        send_lookup(63'h2AAA_AAAA_5555_5555);
        write_start_vcn(63'd0);
        send_random_list(2, 1);
    endtask

    task automatic test_random_traffic();
        int next_cfg;
        next_cfg = items_sent + 300;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= next_cfg)
            begin
                next_cfg = items_sent + 300;
                case ($urandom_range(0, 3))
                    0: write_start_vcn(63'd0);
                    1: write_start_vcn(VCN_MAX);
                    2: write_start_vcn(63'($urandom_range(1, 5000)));
                    default: write_start_vcn(63'({$urandom, $urandom}));
                endcase
            end
            // one long stretch with no idling anywhere
            quiet = (items_sent > 700 && items_sent < 950);
            if (items_sent > 1100 && items_sent < 1120)
                drain();                      // hold off until all results are in
            send_random_list($urandom_range(1, 8), $urandom_range(0, 4) != 0);
            repeat ($urandom_range(0, 3)) send_lookup(pick_query());
        end
        quiet = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        func = 1'b0;
        list_byte = '0;
        list_start = 1'b0;
        query_vcn = '0;
        sh_start_vcn = 0;
        sh_phase = PH_HDR;
        sh_len_size = 0;
        sh_off_size = 0;
        sh_bytes_seen = 0;
        sh_acc = 0;
        sh_vcn = 0;
        sh_lcn = 0;
        sh_runs = 0;
        sh_begin_vcn = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_list();
        test_bad_header();
        test_restart_mid_run();
        test_lookups();
        test_full_table();
        test_start_vcn_settings();
        test_random_traffic();

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // A result still owed at the end is caught by the watchdog via drain();
    // anything left after drain is impossible since drain waits for it.

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/erd_pkg.sv
rtl/core/erd_cell.sv
rtl/core/extent_runlist_decoder.sv
test/extent_runlist_decoder_tb.sv
